// ===== hw/rtl/rmq_pkg.sv =====
// Shared types, constants and width helpers for the matrix-to-quaternion block.
`timescale 1ns / 1ps

package rmq_pkg;

    // Field widths of the stream items
    localparam int ENTRY_W = 16;
    localparam int QUAT_W_W = 15;
    localparam int QUAT_V_W = 16;
    localparam int IN_TDATA_W = 144;
    localparam int OUT_TDATA_W = 64;

    // Largest magnitude a component may carry
    localparam logic [QUAT_W_W-1:0] MAG_MAX = 15'h7fff;

    typedef logic signed [ENTRY_W-1:0] t_entry;

    // Sign flags of the vector part, set when the off-diagonal difference is negative
    typedef struct packed {
        logic x;
        logic y;
        logic z;
    } t_sign;

    // Width of the signed diagonal sum, covering one plus three entries
    function automatic int sum_w(input int frac_bits);
        int base;
        base = (frac_bits > 17) ? frac_bits : 17;
        return base + 2;
    endfunction

    // Width of the square root result, one bit per pipeline stage
    function automatic int root_w(input int frac_bits);
        int rad;
        rad = sum_w(frac_bits) - 1 + frac_bits;
        return (rad + 1) / 2;
    endfunction

endpackage

// ===== hw/rtl/rmq_sum.sv =====
// Input stage: diagonal sums clamped at zero and scaled into radicands, plus sign flags.
`timescale 1ns / 1ps

module rmq_sum #(
    parameter int FRAC_BITS = 14
) (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  rmq_pkg::t_entry                i_m00,
    input  rmq_pkg::t_entry                i_m01,
    input  rmq_pkg::t_entry                i_m02,
    input  rmq_pkg::t_entry                i_m10,
    input  rmq_pkg::t_entry                i_m11,
    input  rmq_pkg::t_entry                i_m12,
    input  rmq_pkg::t_entry                i_m20,
    input  rmq_pkg::t_entry                i_m21,
    input  rmq_pkg::t_entry                i_m22,
    output logic [2*rmq_pkg::root_w(FRAC_BITS)-1:0] o_rad_w,
    output logic [2*rmq_pkg::root_w(FRAC_BITS)-1:0] o_rad_x,
    output logic [2*rmq_pkg::root_w(FRAC_BITS)-1:0] o_rad_y,
    output logic [2*rmq_pkg::root_w(FRAC_BITS)-1:0] o_rad_z,
    output rmq_pkg::t_sign                 o_sign
);

    localparam int SW = rmq_pkg::sum_w(FRAC_BITS);
    localparam int RADW = 2 * rmq_pkg::root_w(FRAC_BITS);
    localparam int DW = rmq_pkg::ENTRY_W + 1;

    logic signed [SW-1:0] one;
    logic signed [SW-1:0] a00, a11, a22;
    logic signed [SW-1:0] s_w, s_x, s_y, s_z;
    logic signed [DW-1:0] d_x, d_y, d_z;
    logic [RADW-1:0] n_rad_w, n_rad_x, n_rad_y, n_rad_z;
    rmq_pkg::t_sign n_sign;

    logic [RADW-1:0] r_rad_w, r_rad_x, r_rad_y, r_rad_z;
    rmq_pkg::t_sign r_sign;

    assign one = SW'(1) << FRAC_BITS;
    assign a00 = SW'(i_m00);
    assign a11 = SW'(i_m11);
    assign a22 = SW'(i_m22);

    // Form the four signed diagonal sums
    assign s_w = one + a00 + a11 + a22;
    assign s_x = one + a00 - a11 - a22;
    assign s_y = one - a00 + a11 - a22;
    assign s_z = one - a00 - a11 + a22;

    // Clamp at zero and scale by one more fraction width for the root
    always_comb begin
        n_rad_w = (s_w <= 0) ? '0 : RADW'({s_w[SW-2:0], {FRAC_BITS{1'b0}}});
        n_rad_x = (s_x <= 0) ? '0 : RADW'({s_x[SW-2:0], {FRAC_BITS{1'b0}}});
        n_rad_y = (s_y <= 0) ? '0 : RADW'({s_y[SW-2:0], {FRAC_BITS{1'b0}}});
        n_rad_z = (s_z <= 0) ? '0 : RADW'({s_z[SW-2:0], {FRAC_BITS{1'b0}}});
    end

    // Off-diagonal differences pick the vector signs
    assign d_x = DW'(i_m21) - DW'(i_m12);
    assign d_y = DW'(i_m02) - DW'(i_m20);
    assign d_z = DW'(i_m10) - DW'(i_m01);
    assign n_sign = '{x: d_x[DW-1], y: d_y[DW-1], z: d_z[DW-1]};

    // Hold on stall, advance otherwise
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad_w <= n_rad_w;
            r_rad_x <= n_rad_x;
            r_rad_y <= n_rad_y;
            r_rad_z <= n_rad_z;
            r_sign  <= n_sign;
        end
    end

    assign o_rad_w = r_rad_w;
    assign o_rad_x = r_rad_x;
    assign o_rad_y = r_rad_y;
    assign o_rad_z = r_rad_z;
    assign o_sign  = r_sign;

endmodule

// ===== hw/rtl/rmq_sqrt.sv =====
// Pipelined digit-by-digit square root, one root bit per register stage, with a sign sideband.
`timescale 1ns / 1ps

module rmq_sqrt #(
    parameter int FRAC_BITS = 14
) (
    input  logic                                   i_clk,
    input  logic                                   i_en,
    input  logic [2*rmq_pkg::root_w(FRAC_BITS)-1:0] i_rad,
    input  logic                                   i_neg,
    output logic [rmq_pkg::root_w(FRAC_BITS)-1:0]   o_root,
    output logic                                   o_neg
);

    localparam int RTW = rmq_pkg::root_w(FRAC_BITS);
    localparam int RADW = 2 * RTW;
    localparam int REM_W = RTW + 3;

    logic [REM_W-1:0] r_rem  [RTW];
    logic [RTW-1:0]   r_root [RTW];
    logic [RADW-1:0]  r_rad  [RTW];
    logic             r_neg  [RTW];

    for (genvar k = 0; k < RTW; k++) begin : g_stage
        logic [REM_W-1:0] rem_in;
        logic [RTW-1:0]   root_in;
        logic [RADW-1:0]  rad_in;
        logic             neg_in;
        logic [REM_W-1:0] shifted;
        logic [REM_W-1:0] trial;
        logic             take;
        logic [REM_W-1:0] n_rem;
        logic [RTW-1:0]   n_root;
        logic [RADW-1:0]  n_rad;

        // Select the stage input: ports for the first stage, previous stage otherwise
        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = i_rad;
            assign neg_in  = i_neg;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign rad_in  = r_rad[k-1];
            assign neg_in  = r_neg[k-1];
        end

        // Bring down two radicand bits and try to subtract the next odd term
        assign shifted = {rem_in[REM_W-3:0], rad_in[RADW-1 -: 2]};
        assign trial   = {1'b0, root_in, 2'b01};
        assign take    = (shifted >= trial);
        assign n_rem   = take ? (shifted - trial) : shifted;
        assign n_root  = {root_in[RTW-2:0], take};
        assign n_rad   = {rad_in[RADW-3:0], 2'b00};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
                r_rad[k]  <= n_rad;
                r_neg[k]  <= neg_in;
            end
        end
    end

    assign o_root = r_root[RTW-1];
    assign o_neg  = r_neg[RTW-1];

endmodule

// ===== hw/rtl/rmq_out.sv =====
// Output stage: halve and saturate the roots, apply the vector signs, register the result.
`timescale 1ns / 1ps

module rmq_out #(
    parameter int FRAC_BITS = 14
) (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic [rmq_pkg::root_w(FRAC_BITS)-1:0] i_root_w,
    input  logic [rmq_pkg::root_w(FRAC_BITS)-1:0] i_root_x,
    input  logic [rmq_pkg::root_w(FRAC_BITS)-1:0] i_root_y,
    input  logic [rmq_pkg::root_w(FRAC_BITS)-1:0] i_root_z,
    input  rmq_pkg::t_sign                       i_sign,
    output logic [rmq_pkg::OUT_TDATA_W-1:0]      o_tdata
);

    localparam int RTW = rmq_pkg::root_w(FRAC_BITS);
    localparam int HW = RTW - 1;
    localparam int EW = (HW > 16) ? HW : 16;
    localparam int MW = rmq_pkg::QUAT_W_W;
    localparam int VW = rmq_pkg::QUAT_V_W;

    logic [EW-1:0] ext_w, ext_x, ext_y, ext_z;
    logic [MW-1:0] mag_w, mag_x, mag_y, mag_z;
    logic [VW-1:0] v_x, v_y, v_z;
    logic [rmq_pkg::OUT_TDATA_W-1:0] n_tdata;
    logic [rmq_pkg::OUT_TDATA_W-1:0] r_tdata;

    // Halve by truncation
    assign ext_w = EW'(i_root_w[RTW-1:1]);
    assign ext_x = EW'(i_root_x[RTW-1:1]);
    assign ext_y = EW'(i_root_y[RTW-1:1]);
    assign ext_z = EW'(i_root_z[RTW-1:1]);

    // Saturate at the largest magnitude
    assign mag_w = (ext_w > EW'(rmq_pkg::MAG_MAX)) ? rmq_pkg::MAG_MAX : ext_w[MW-1:0];
    assign mag_x = (ext_x > EW'(rmq_pkg::MAG_MAX)) ? rmq_pkg::MAG_MAX : ext_x[MW-1:0];
    assign mag_y = (ext_y > EW'(rmq_pkg::MAG_MAX)) ? rmq_pkg::MAG_MAX : ext_y[MW-1:0];
    assign mag_z = (ext_z > EW'(rmq_pkg::MAG_MAX)) ? rmq_pkg::MAG_MAX : ext_z[MW-1:0];

    // Negate where the difference was negative; zero stays zero
    assign v_x = i_sign.x ? (VW'(0) - VW'(mag_x)) : VW'(mag_x);
    assign v_y = i_sign.y ? (VW'(0) - VW'(mag_y)) : VW'(mag_y);
    assign v_z = i_sign.z ? (VW'(0) - VW'(mag_z)) : VW'(mag_z);

    assign n_tdata = {1'b0, v_z, v_y, v_x, mag_w};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tdata <= n_tdata;
        end
    end

    assign o_tdata = r_tdata;

endmodule

// ===== hw/rtl/rotation_matrix_to_quaternion.sv =====
// Top level: 3x3 rotation matrix in, unit quaternion out, fully pipelined.
//
// Usage: one matrix enters per transfer on the slave stream, nine signed entries
// with FRAC_BITS fraction bits packed row by row. One quaternion leaves per matrix
// on the master stream: w as a non-negative magnitude, x, y and z signed, each a
// halved, truncated square root of a clamped diagonal sum.
// Stages: a register for the sums, then the four square-root pipelines, then an
// output register that halves, saturates and signs the roots and holds the result.
// Throughput: one matrix per cycle while the receiver takes results; the stages
// each resolve one root bit with a single compare and subtract.
// Reset: clears every stage valid bit and the output valid; data registers keep
// whatever they held.
// Stall: when a result waits and the receiver holds tready low, the whole pipe
// holds and s_axis_tready drops; nothing in flight is lost or repeated.
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion #(
    parameter int FRAC_BITS = 14
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // row0_col0, row0_col1, row0_col2, row1_col0, row1_col1, row1_col2,
    // row2_col0, row2_col1, row2_col2 (16 bits each)
    input  logic [143:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // quat_w [14:0], quat_x [30:15], quat_y [46:31], quat_z [62:47], zero [63]
    output logic [63:0]  o_m_axis_tdata
);

    localparam int RTW = rmq_pkg::root_w(FRAC_BITS);
    localparam int RADW = 2 * RTW;
    localparam int DEPTH = RTW + 1;
    localparam int EW = rmq_pkg::ENTRY_W;

    logic en;
    logic [RADW-1:0] rad_w, rad_x, rad_y, rad_z;
    rmq_pkg::t_sign sign_in;
    rmq_pkg::t_sign sign_out;
    logic [RTW-1:0] root_w, root_x, root_y, root_z;

    logic [DEPTH-1:0] r_vld;
    logic [DEPTH-1:0] n_vld;
    logic r_out_vld;

    // Advance the whole pipe whenever the output slot is free or being taken
    assign en = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = en;

    rmq_sum #(
        .FRAC_BITS(FRAC_BITS)
    ) u_sum (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_m00   (i_s_axis_tdata[0*EW +: EW]),
        .i_m01   (i_s_axis_tdata[1*EW +: EW]),
        .i_m02   (i_s_axis_tdata[2*EW +: EW]),
        .i_m10   (i_s_axis_tdata[3*EW +: EW]),
        .i_m11   (i_s_axis_tdata[4*EW +: EW]),
        .i_m12   (i_s_axis_tdata[5*EW +: EW]),
        .i_m20   (i_s_axis_tdata[6*EW +: EW]),
        .i_m21   (i_s_axis_tdata[7*EW +: EW]),
        .i_m22   (i_s_axis_tdata[8*EW +: EW]),
        .o_rad_w (rad_w),
        .o_rad_x (rad_x),
        .o_rad_y (rad_y),
        .o_rad_z (rad_z),
        .o_sign  (sign_in)
    );

    // The w lane carries no sign; its sideband is tied low and left open at the end
    rmq_sqrt #(
        .FRAC_BITS(FRAC_BITS)
    ) u_sqrt_w (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (rad_w),
        .i_neg  (1'b0),
        .o_root (root_w),
        .o_neg  ()
    );

    rmq_sqrt #(
        .FRAC_BITS(FRAC_BITS)
    ) u_sqrt_x (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (rad_x),
        .i_neg  (sign_in.x),
        .o_root (root_x),
        .o_neg  (sign_out.x)
    );

    rmq_sqrt #(
        .FRAC_BITS(FRAC_BITS)
    ) u_sqrt_y (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (rad_y),
        .i_neg  (sign_in.y),
        .o_root (root_y),
        .o_neg  (sign_out.y)
    );

    rmq_sqrt #(
        .FRAC_BITS(FRAC_BITS)
    ) u_sqrt_z (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (rad_z),
        .i_neg  (sign_in.z),
        .o_root (root_z),
        .o_neg  (sign_out.z)
    );

    rmq_out #(
        .FRAC_BITS(FRAC_BITS)
    ) u_out (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_root_w (root_w),
        .i_root_x (root_x),
        .i_root_y (root_y),
        .i_root_z (root_z),
        .i_sign   (sign_out),
        .o_tdata  (o_m_axis_tdata)
    );

    // Shift valid bits alongside the data stages
    assign n_vld = {r_vld[DEPTH-2:0], i_s_axis_tvalid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_vld     <= n_vld;
            r_out_vld <= r_vld[DEPTH-1];
        end
    end

    assign o_m_axis_tvalid = r_out_vld;

endmodule

// ===== dv/rotation_matrix_to_quaternion_tb.sv =====
// Self-checking testbench for the matrix-to-quaternion block: stream stimulus and scoreboard.
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion_tb;

    localparam int FRAC_BITS = 14;
    localparam int CLK_HALF = 6;
    localparam int RST_CYCLES = 12;
    localparam int DRAIN_CYCLES = 40;
    localparam int LONG_HOLD = 300;
    localparam int MAX_PRINTS = 40;
    localparam longint ONE = longint'(1) << FRAC_BITS;

    // Matrix as carried on the input stream, row0_col0 in the lowest bits
    typedef struct packed {
        rmq_pkg::t_entry r2c2;
        rmq_pkg::t_entry r2c1;
        rmq_pkg::t_entry r2c0;
        rmq_pkg::t_entry r1c2;
        rmq_pkg::t_entry r1c1;
        rmq_pkg::t_entry r1c0;
        rmq_pkg::t_entry r0c2;
        rmq_pkg::t_entry r0c1;
        rmq_pkg::t_entry r0c0;
    } t_matrix;

    // Quaternion as carried on the output stream, w in the lowest bits
    typedef struct packed {
        logic                                pad;
        logic signed [rmq_pkg::QUAT_V_W-1:0] z;
        logic signed [rmq_pkg::QUAT_V_W-1:0] y;
        logic signed [rmq_pkg::QUAT_V_W-1:0] x;
        logic [rmq_pkg::QUAT_W_W-1:0]        w;
    } t_quat;

    typedef enum int {RX_OPEN, RX_COIN, RX_COMB, RX_SLOW} t_rx_mode;

    // Predicts one quaternion per accepted matrix and checks results in order
    class quat_scoreboard;
        t_quat expected_quats[$];
        int    mismatches;
        int    matched;

        function new();
            mismatches = 0;
            matched = 0;
        endfunction

        // Truncated integer square root, one result bit per step from the top
        function logic [63:0] int_sqrt(logic [63:0] v);
            logic [63:0] root;
            logic [63:0] trial;
            root = '0;
            for (int i = 31; i >= 0; i--) begin
                trial = root | (64'h1 << i);
                if (trial * trial <= v) begin
                    root = trial;
                end
            end
            return root;
        endfunction

        // Halved root of a clamped diagonal sum, saturated to the magnitude range
        function logic [rmq_pkg::QUAT_W_W-1:0] half_root(longint s);
            logic [63:0] r;
            if (s <= 0) begin
                return '0;
            end
            r = int_sqrt(64'(s) << FRAC_BITS) >> 1;
            if (r > 64'(rmq_pkg::MAG_MAX)) begin
                r = 64'(rmq_pkg::MAG_MAX);
            end
            return r[rmq_pkg::QUAT_W_W-1:0];
        endfunction

        // Negate the magnitude when the difference is negative; zero stays zero
        function logic signed [rmq_pkg::QUAT_V_W-1:0] signed_mag(
            logic [rmq_pkg::QUAT_W_W-1:0] mag, longint diff);
            longint v;
            v = longint'(mag);
            if (diff < 0) begin
                v = -v;
            end
            return v[rmq_pkg::QUAT_V_W-1:0];
        endfunction

        function t_quat predict_quat(t_matrix m);
            longint a;
            longint b;
            longint c;
            t_quat  q;
            a = m.r0c0;
            b = m.r1c1;
            c = m.r2c2;
            q.pad = 1'b0;
            q.w = half_root(ONE + a + b + c);
            q.x = signed_mag(half_root(ONE + a - b - c), longint'(m.r2c1) - longint'(m.r1c2));
            q.y = signed_mag(half_root(ONE - a + b - c), longint'(m.r0c2) - longint'(m.r2c0));
            q.z = signed_mag(half_root(ONE - a - b + c), longint'(m.r1c0) - longint'(m.r0c1));
            return q;
        endfunction

        function void note_matrix(t_matrix m);
            expected_quats.push_back(predict_quat(m));
        endfunction

        function int pending();
            return expected_quats.size();
        endfunction

        // Print one line per mismatch (first few only) and count every one
        task report(string what);
            mismatches++;
            if (mismatches <= MAX_PRINTS) begin
                $display("MISMATCH @%0t: %s", $realtime, what);
            end
        endtask

        task check_result(t_quat got);
            t_quat want;
            int    before_cnt;
            if (expected_quats.size() == 0) begin
                report($sformatf("result %h with no matrix outstanding", got));
                return;
            end
            want = expected_quats.pop_front();
            before_cnt = mismatches;
            if (got.w !== want.w) begin
                report($sformatf("quat_w got %0d want %0d", got.w, want.w));
            end
            if (got.x !== want.x) begin
                report($sformatf("quat_x got %0d want %0d", got.x, want.x));
            end
            if (got.y !== want.y) begin
                report($sformatf("quat_y got %0d want %0d", got.y, want.y));
            end
            if (got.z !== want.z) begin
                report($sformatf("quat_z got %0d want %0d", got.z, want.z));
            end
            if (got.pad !== 1'b0) begin
                report($sformatf("pad bit got %b want 0", got.pad));
            end
            if (mismatches == before_cnt) begin
                matched++;
            end
        endtask
    endclass

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    // row0_col0 .. row2_col2, 16 bits each, lowest bits first
    logic [143:0] i_s_axis_tdata = '0;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    // quat_w [14:0], quat_x [30:15], quat_y [46:31], quat_z [62:47], zero [63]
    logic [63:0]  o_m_axis_tdata;

    quat_scoreboard sb = new();

    int       matrices_sent = 0;
    int       hold_requests = 0;
    int       hold_served = 0;
    int       hold_left = 0;
    int       mode_left = 0;
    int       rx_cycle = 0;
    bit       rx_free = 1'b1;
    t_rx_mode rx_mode = RX_OPEN;

    rotation_matrix_to_quaternion #(
        .FRAC_BITS(FRAC_BITS)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Check each output transfer, then pick the next ready value
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            sb.check_result(o_m_axis_tdata);
        end
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = LONG_HOLD;
        end
        if (mode_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            mode_left = $urandom_range(32, 200);
        end else begin
            mode_left--;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else if (rx_free) begin
            i_m_axis_tready <= 1'b1;
        end else begin
            case (rx_mode)
                RX_OPEN: i_m_axis_tready <= 1'b1;
                RX_COIN: i_m_axis_tready <= ($urandom_range(0, 99) < 70);
                RX_COMB: i_m_axis_tready <= ((rx_cycle % 5) != 2) && ((rx_cycle % 7) != 4);
                RX_SLOW: i_m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: i_m_axis_tready <= 1'b1;
            endcase
        end
        rx_cycle++;
    end

    function automatic rmq_pkg::t_entry sat16(longint v);
        if (v > 32767) begin
            return 16'sh7fff;
        end
        if (v < -32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    function automatic t_matrix build_matrix(longint d0, longint d1, longint d2,
                                             longint o01, longint o02, longint o10,
                                             longint o12, longint o20, longint o21);
        t_matrix m;
        m.r0c0 = sat16(d0);
        m.r1c1 = sat16(d1);
        m.r2c2 = sat16(d2);
        m.r0c1 = sat16(o01);
        m.r0c2 = sat16(o02);
        m.r1c0 = sat16(o10);
        m.r1c2 = sat16(o12);
        m.r2c0 = sat16(o20);
        m.r2c1 = sat16(o21);
        return m;
    endfunction

    // Scale a real entry to Q2.14 with a little jitter on the last bits
    function automatic rmq_pkg::t_entry to_fixed(real v);
        longint r;
        r = $rtoi(v * 16384.0 + ((v >= 0.0) ? 0.5 : -0.5));
        return sat16(r + longint'($urandom_range(0, 4)) - 2);
    endfunction

    function automatic real rand_unit();
        return (real'($urandom_range(0, 20000)) - 10000.0) / 10000.0;
    endfunction

    // Mostly true rotations; the rest raw bits, sums near zero, and extreme values
    function automatic t_matrix random_matrix();
        t_matrix      m;
        logic [159:0] raw;
        longint       pick[8];
        longint       a;
        longint       b;
        longint       sa;
        longint       sb_;
        longint       sc;
        real          qw;
        real          qx;
        real          qy;
        real          qz;
        real          n;
        int           kind;
        int           tgt;
        pick = '{-32768, -32767, -16384, -1, 0, 1, 16384, 32767};
        kind = $urandom_range(0, 99);
        if (kind < 60) begin
            qw = rand_unit();
            qx = rand_unit();
            qy = rand_unit();
            qz = rand_unit();
            n = $sqrt(qw * qw + qx * qx + qy * qy + qz * qz);
            if (n < 0.001) begin
                qw = 1.0;
                qx = 0.0;
                qy = 0.0;
                qz = 0.0;
                n = 1.0;
            end
            qw = qw / n;
            qx = qx / n;
            qy = qy / n;
            qz = qz / n;
            m.r0c0 = to_fixed(1.0 - 2.0 * (qy * qy + qz * qz));
            m.r0c1 = to_fixed(2.0 * (qx * qy - qz * qw));
            m.r0c2 = to_fixed(2.0 * (qx * qz + qy * qw));
            m.r1c0 = to_fixed(2.0 * (qx * qy + qz * qw));
            m.r1c1 = to_fixed(1.0 - 2.0 * (qx * qx + qz * qz));
            m.r1c2 = to_fixed(2.0 * (qy * qz - qx * qw));
            m.r2c0 = to_fixed(2.0 * (qx * qz - qy * qw));
            m.r2c1 = to_fixed(2.0 * (qy * qz + qx * qw));
            m.r2c2 = to_fixed(1.0 - 2.0 * (qx * qx + qy * qy));
        end else if (kind < 75) begin
            raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
            m = raw[143:0];
        end else if (kind < 88) begin
            // Put one component's sum within a few LSBs of zero, off-diagonals nearly equal
            tgt = $urandom_range(0, 3);
            sa = (tgt == 0 || tgt == 1) ? 1 : -1;
            sb_ = (tgt == 0 || tgt == 2) ? 1 : -1;
            sc = (tgt == 0 || tgt == 3) ? 1 : -1;
            a = longint'($urandom_range(0, 16000)) - 8000;
            b = longint'($urandom_range(0, 16000)) - 8000;
            m.r0c0 = sat16(a);
            m.r1c1 = sat16(b);
            m.r2c2 = sat16(sc * (longint'($urandom_range(0, 6)) - 3 - ONE - sa * a - sb_ * b));
            raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
            m.r0c1 = raw[15:0];
            m.r1c2 = raw[31:16];
            m.r2c0 = raw[47:32];
            m.r1c0 = sat16(longint'(m.r0c1) + longint'($urandom_range(0, 2)) - 1);
            m.r2c1 = sat16(longint'(m.r1c2) + longint'($urandom_range(0, 2)) - 1);
            m.r0c2 = sat16(longint'(m.r2c0) + longint'($urandom_range(0, 2)) - 1);
        end else begin
            m = build_matrix(pick[$urandom_range(0, 7)], pick[$urandom_range(0, 7)],
                             pick[$urandom_range(0, 7)], pick[$urandom_range(0, 7)],
                             pick[$urandom_range(0, 7)], pick[$urandom_range(0, 7)],
                             pick[$urandom_range(0, 7)], pick[$urandom_range(0, 7)],
                             pick[$urandom_range(0, 7)]);
        end
        return m;
    endfunction

    // Offer one matrix and hold it until the block takes the transfer
    task automatic offer_matrix(input t_matrix m);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= m;
        do begin
            @(posedge i_clk);
        end while (!o_s_axis_tready);
        sb.note_matrix(m);
        matrices_sent++;
    endtask

    task automatic pause_sender(input int cycles);
        i_s_axis_tvalid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Send random matrices in bursts, with gaps between bursts when asked
    task automatic send_random(input int count, input bit with_gaps);
        int left;
        int burst;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 40);
            if (burst > left) begin
                burst = left;
            end
            repeat (burst) offer_matrix(random_matrix());
            left -= burst;
            if (with_gaps) begin
                pause_sender($urandom_range(1, 8));
            end
        end
    endtask

    // Stop sending until every outstanding quaternion has come back
    task automatic wait_drained();
        pause_sender(1);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        t_matrix directed_set[$];
        int      directed_cnt;
        // Identity, zero, saturated entries and the three half-turns
        directed_set.push_back(build_matrix(16384, 16384, 16384, 0, 0, 0, 0, 0, 0));
        directed_set.push_back(build_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0));
        directed_set.push_back(build_matrix(32767, 32767, 32767,
                                            32767, 32767, 32767, 32767, 32767, 32767));
        directed_set.push_back(build_matrix(-32768, -32768, -32768,
                                            -32768, -32768, -32768, -32768, -32768, -32768));
        directed_set.push_back(build_matrix(16384, -16384, -16384, 0, 0, 0, 0, 0, 0));
        directed_set.push_back(build_matrix(-16384, 16384, -16384, 0, 0, 0, 0, 0, 0));
        directed_set.push_back(build_matrix(-16384, -16384, 16384, 0, 0, 0, 0, 0, 0));
        // Quarter turn about z and half turn about the x=y diagonal
        directed_set.push_back(build_matrix(0, 0, 16384, -16384, 0, 16384, 0, 0, 0));
        directed_set.push_back(build_matrix(0, 0, -16384, 16384, 0, 16384, 0, 0, 0));
        // Zero magnitudes with negative differences must stay plain zero
        directed_set.push_back(build_matrix(16384, 16384, 16384, 1, -5, -1, 100, 5, -100));
        // Largest differences of either sign
        directed_set.push_back(build_matrix(32767, -32768, -32768,
                                            32767, 32767, -32768, 32767, -32768, -32768));
        directed_set.push_back(build_matrix(-32768, 32767, -32768,
                                            -32768, -32768, 32767, -32768, 32767, 32767));
        // Sums of exactly zero, one and minus one
        directed_set.push_back(build_matrix(-16384, 0, 0, 7, 7, 7, 7, 7, 7));
        directed_set.push_back(build_matrix(-16383, 0, 0, 0, 0, 0, 0, 0, 0));
        directed_set.push_back(build_matrix(-16385, 0, 0, 0, 0, 0, 0, 0, 0));
        // Equal off-diagonal pairs give zero differences with large magnitudes
        directed_set.push_back(build_matrix(-32768, 32767, -1,
                                            1234, -1234, 1234, 4321, -1234, 4321));
        directed_set.push_back(build_matrix(32767, 32767, 32767,
                                            -32768, -32768, -32768, -32768, -32768, -32768));
        // Alternating bit patterns
        directed_set.push_back(build_matrix(21845, -21846, 21845,
                                            21845, -21846, -21846, 21845, 21845, -21846));
        directed_set.push_back(build_matrix(-21846, 21845, -21846,
                                            -21846, 21845, 21845, -21846, -21846, 21845));
        directed_cnt = directed_set.size();

        // Hold reset, then release it on a clock edge
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed matrices back to back with an open receiver
        rx_free = 1'b1;
        foreach (directed_set[i]) begin
            offer_matrix(directed_set[i]);
        end
        wait_drained();

        // Random stretch with no idling on either side
        send_random(300, 1'b0);

        // Bursty sender against a stalling receiver
        rx_free = 1'b0;
        send_random(300, 1'b1);

        // Long receiver hold while the sender keeps offering, so the pipe fills
        hold_requests++;
        send_random(200, 1'b0);

        // Let everything drain before going on
        wait_drained();
        send_random(300, 1'b1);
        hold_requests++;
        send_random(200, 1'b1);

        // Wait for the last results, then give stray outputs time to show up
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d matrices (%0d directed), %0d quaternions matched.",
                 matrices_sent, directed_cnt, sb.matched);
        $display("Stimulus mixed rotations, raw bit patterns, near-zero sums and extremes;" );
        $display("%0d field mismatches, %0d results still outstanding.",
                 sb.mismatches, sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #2_000_000;
        $display("Timeout waiting for the block");
        $display("Test completed with failures");
        $finish;
    end

endmodule
